@@ rtl/alte_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// alte_pkg: sizes, payload types and operation codes of the array list table engine.
// No dependencies; used by the channel interfaces and by the top level.
package alte_pkg;

	localparam int CAPACITY = 8;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 4;
	localparam int FILL_W   = 4;
	localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef logic [FUNC_W-1:0]         func_t;
	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0]          pos_t;
	typedef logic [FILL_W-1:0]         fill_t;
	typedef logic [CNT_W-1:0]          cnt_t;
	typedef logic [IDX_W-1:0]          idx_t;
	typedef logic [CMP_W-1:0]          cmp_t;

	localparam func_t FUNC_APPEND  = 3'd0;
	localparam func_t FUNC_INSERT  = 3'd1;
	localparam func_t FUNC_DEL_VAL = 3'd2;
	localparam func_t FUNC_DEL_POS = 3'd3;
	localparam func_t FUNC_COMPACT = 3'd4;

endpackage
`default_nettype wire

@@ rtl/alte_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// alte_req_if: request channel (valid/ready) carrying func, value and position.
// Depends on alte_pkg.
interface alte_req_if;
	import alte_pkg::*;

	logic   valid;
	logic   ready;
	func_t  func;
	value_t value;
	pos_t   position;

	modport source (output valid, output func, output value, output position, input ready);
	modport sink   (input valid, input func, input value, input position, output ready);
endinterface
`default_nettype wire

@@ rtl/alte_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// alte_rsp_if: response channel (valid/ready) carrying success and fill_count.
// Depends on alte_pkg.
interface alte_rsp_if;
	import alte_pkg::*;

	logic  valid;
	logic  ready;
	logic  success;
	fill_t fill_count;

	modport source (output valid, output success, output fill_count, input ready);
	modport sink   (input valid, input success, input fill_count, output ready);
endinterface
`default_nettype wire

@@ rtl/array_list_table_engine_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// array_list_table_engine_unit: bounded ordered entry array with fill count.
// Depends on alte_pkg, alte_req_if, alte_rsp_if.
//
// channel | dir | payload                    | transfer when
// req     | in  | func, value, position      | req.valid && req.ready
// rsp     | out | success, fill_count        | rsp.valid && rsp.ready
//
// One request at a time: the request is accepted in idle, then a walk over the entries
// goes through one read port and one write port, one entry per cycle, then the
// response register is loaded. Append, delete by position, refused insert and unused
// codes are done in their first walk step; insert shifts entries up from the count down
// to the position; delete by value walks from entry 0 to a match, or to the count with
// no match; compact walks all counted entries. Reset clears the count and control;
// entry storage is not reset. A stalled response holds in its register while the
// next request walks; that request's load, and the next accept, wait for its transfer.
module array_list_table_engine_unit (
	input  wire        clk,
	input  wire        arst_n,
	alte_req_if.sink   req,
	alte_rsp_if.source rsp
);
	import alte_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	func_t      op_q;
	value_t     val_q;
	pos_t       pos_q;
	cnt_t       idx_q;
	cnt_t       wr_q;
	cnt_t       cnt_q;
	logic       ok_q;
	logic       rsp_valid_q;
	logic       rsp_ok_q;
	fill_t      rsp_fill_q;

	value_t entries_q [CAPACITY];

	cmp_t   cnt_x, idx_x, pos_x;
	idx_t   rd_idx;
	value_t rd_data;
	logic   we_c;
	idx_t   waddr_c;
	value_t wdata_c;
	logic   done_c, ok_c;
	cnt_t   idx_d, wr_d, cnt_d;
	logic   req_xfer, rsp_load;

	assign req.ready = (state_q == ST_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || rsp.ready);

	assign rsp.valid      = rsp_valid_q;
	assign rsp.success    = rsp_ok_q;
	assign rsp.fill_count = rsp_fill_q;

	assign cnt_x = CMP_W'(cnt_q);
	assign idx_x = CMP_W'(idx_q);
	assign pos_x = CMP_W'(pos_q);

	always_comb begin
		if (op_q == FUNC_INSERT) begin
			rd_idx = IDX_W'(idx_q - cnt_t'(1));
		end else begin
			rd_idx = IDX_W'(idx_q);
		end
	end
	assign rd_data = entries_q[rd_idx];

	always_comb begin
		done_c  = 1'b0;
		ok_c    = 1'b0;
		we_c    = 1'b0;
		waddr_c = IDX_W'(idx_q);
		wdata_c = val_q;
		idx_d   = idx_q;
		wr_d    = wr_q;
		cnt_d   = cnt_q;
		case (op_q)
			FUNC_APPEND: begin
				done_c = 1'b1;
				if (cnt_x < CMP_W'(CAPACITY)) begin
					we_c    = 1'b1;
					waddr_c = IDX_W'(cnt_q);
					cnt_d   = cnt_q + cnt_t'(1);
					ok_c    = 1'b1;
				end
			end
			FUNC_INSERT: begin
				if (cnt_x >= CMP_W'(CAPACITY) || pos_x == '0 || pos_x > cnt_x + cmp_t'(1)) begin
					done_c = 1'b1;
				end else if (idx_x >= pos_x) begin
					we_c    = 1'b1;
					wdata_c = rd_data;
					idx_d   = idx_q - cnt_t'(1);
				end else begin
					we_c   = 1'b1;
					cnt_d  = cnt_q + cnt_t'(1);
					ok_c   = 1'b1;
					done_c = 1'b1;
				end
			end
			FUNC_DEL_VAL: begin
				if (idx_x >= cnt_x) begin
					done_c = 1'b1;
				end else if (rd_data == val_q) begin
					we_c    = 1'b1;
					wdata_c = '0;
					ok_c    = 1'b1;
					done_c  = 1'b1;
				end else begin
					idx_d = idx_q + cnt_t'(1);
				end
			end
			FUNC_DEL_POS: begin
				done_c = 1'b1;
				if (pos_x < cnt_x) begin
					we_c    = 1'b1;
					waddr_c = IDX_W'(pos_q);
					wdata_c = '0;
					ok_c    = 1'b1;
				end
			end
			FUNC_COMPACT: begin
				if (idx_x >= cnt_x) begin
					cnt_d  = wr_q;
					ok_c   = 1'b1;
					done_c = 1'b1;
				end else begin
					if (rd_data != '0) begin
						we_c    = 1'b1;
						waddr_c = IDX_W'(wr_q);
						wdata_c = rd_data;
						wr_d    = wr_q + cnt_t'(1);
					end
					idx_d = idx_q + cnt_t'(1);
				end
			end
			default: begin
				done_c = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && we_c) begin
			entries_q[waddr_c] <= wdata_c;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			op_q  <= req.func;
			val_q <= req.value;
			pos_q <= req.position;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			wr_q        <= '0;
			cnt_q       <= '0;
			ok_q        <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_ok_q    <= 1'b0;
			rsp_fill_q  <= '0;
		end else begin
			if (rsp_valid_q && rsp.ready && !rsp_load) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_xfer) begin
						state_q <= ST_RUN;
						wr_q    <= '0;
						if (req.func == FUNC_INSERT) begin
							idx_q <= cnt_q;
						end else begin
							idx_q <= '0;
						end
					end
				end
				ST_RUN: begin
					idx_q <= idx_d;
					wr_q  <= wr_d;
					cnt_q <= cnt_d;
					if (done_c) begin
						ok_q    <= ok_c;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (rsp_load) begin
						rsp_valid_q <= 1'b1;
						rsp_ok_q    <= ok_q;
						rsp_fill_q  <= FILL_W'(cnt_q);
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(cnt_q) <= CMP_W'(CAPACITY))
		else $error("fill count above capacity");

	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> CMP_W'(idx_q) <= CMP_W'(CAPACITY))
		else $error("walk index above capacity");

	a_accept_run: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == ST_RUN && !req.ready)
		else $error("accepted request did not start a walk");

	a_compact_ok: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN && op_q == FUNC_COMPACT && done_c |=> ok_q && cnt_q <= $past(cnt_q))
		else $error("compact failed or grew the count");

endmodule
`default_nettype wire
